// ===== src/gbba_pkg.sv =====
// Shared types and constants of the grouped bitmap block allocator.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package gbba_pkg;

  // Field and register widths
  localparam int CMD_W     = 2;
  localparam int BLK_W     = 14;
  localparam int ST_W      = 2;
  localparam int BPG_W     = 11;
  localparam int GRP_W     = 4;
  localparam int CNT_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Bitmap row geometry: one memory row holds 64 used bits
  localparam int ROW_BITS = 64;
  localparam int ROW_SH   = 6;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BPG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRP = 1'd1;

  // Register reset values and count ceiling
  localparam logic [BPG_W-1:0] BPG_RST   = 11'd1024;
  localparam logic [GRP_W-1:0] GRP_RST   = 4'd8;
  localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_GSCAN,
    S_ARD,
    S_ACHK,
    S_FDIV,
    S_FRD,
    S_FCHK,
    S_CLEAR,
    S_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic grp_next;
    logic rd;
    logic row_next;
    logic alloc_wr;
    logic free_wr;
    logic clr_step;
    logic set_full;
    logic set_bad;
    logic out_load;
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic grp_nz;
    logic grp_last;
    logic num_zero;
    logic rem_lt_bpg;
    logic row_found;
    logic row_last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/gbba_ctrl.sv =====
// Sequencing state machine of the block allocator.
// Depends on gbba_pkg; drives ctrl_t commands into gbba_dp and reads its sts_t.
`timescale 1ns / 1ps

module gbba_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [gbba_pkg::CMD_W-1:0] in_cmd_i,
  output logic                    in_stall_o,
  input  gbba_pkg::sts_t          sts_i,
  output gbba_pkg::ctrl_t         ctl_o
);
  import gbba_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_ALLOC: state_d = S_GSCAN;
            CMD_FREE:  state_d = S_FDIV;
            CMD_CLEAR: state_d = S_CLEAR;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_GSCAN: begin
        if (sts_i.grp_nz) state_d = S_ARD;
        else if (sts_i.grp_last) state_d = S_DONE;
      end
      S_ARD: state_d = S_ACHK;
      S_ACHK: begin
        if (sts_i.row_found || sts_i.row_last) state_d = S_DONE;
        else state_d = S_ARD;
      end
      S_FDIV: begin
        if (sts_i.num_zero) state_d = S_DONE;
        else if (sts_i.rem_lt_bpg) state_d = S_FRD;
        else if (sts_i.grp_last) state_d = S_DONE;
      end
      S_FRD:   state_d = S_FCHK;
      S_FCHK:  state_d = S_DONE;
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  // Command outputs
  always_comb begin
    ctl_o = '0;
    unique case (state_q)
      S_INIT:  ctl_o.clr_step = 1'b1;
      S_IDLE:  ctl_o.load = in_valid_i;
      S_GSCAN: begin
        if (!sts_i.grp_nz) begin
          if (sts_i.grp_last) ctl_o.set_full = 1'b1;
          else ctl_o.grp_next = 1'b1;
        end
      end
      S_ARD:   ctl_o.rd = 1'b1;
      S_ACHK: begin
        if (sts_i.row_found) ctl_o.alloc_wr = 1'b1;
        else if (sts_i.row_last) ctl_o.set_full = 1'b1;
        else ctl_o.row_next = 1'b1;
      end
      S_FDIV: begin
        if (sts_i.num_zero) ctl_o.set_bad = 1'b1;
        else if (!sts_i.rem_lt_bpg) begin
          if (sts_i.grp_last) ctl_o.set_bad = 1'b1;
          else ctl_o.grp_next = 1'b1;
        end
      end
      S_FRD:   ctl_o.rd = 1'b1;
      S_FCHK:  ctl_o.free_wr = 1'b1;
      S_CLEAR: ctl_o.clr_step = 1'b1;
      S_DONE:  ctl_o.out_load = sts_i.out_free;
      default: ctl_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  // Every accepted transaction leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted transaction did not leave idle");

  // An allocation only writes a row back when it had a clear bit
  a_alloc_needs_free_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.alloc_wr |-> sts_i.row_found)
    else $error("allocation write on a full row");

  // Read data is checked in the cycle after the read
  a_read_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.rd |=> (state_q == S_ACHK || state_q == S_FCHK))
    else $error("row read not followed by a check");

  // A finished result is handed over once the output register is free
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && sts_i.out_free) |=> (state_q == S_IDLE))
    else $error("result hand-over did not return to idle");
`endif

endmodule

// ===== src/gbba_dp.sv =====
// Datapath of the block allocator: configuration, free counts, bitmap memory,
// group walk, row search and result registers. Depends on gbba_pkg.
`timescale 1ns / 1ps

module gbba_dp #(
  parameter int MAX_GROUPS           = 8,
  parameter int MAX_BLOCKS_PER_GROUP = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gbba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gbba_pkg::BPG_W-1:0]    cfg_data_i,
  input  logic [gbba_pkg::CMD_W-1:0]    in_cmd_i,
  input  logic [gbba_pkg::BLK_W-1:0]    in_block_number_i,
  input  gbba_pkg::ctrl_t               ctl_i,
  output gbba_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gbba_pkg::BLK_W-1:0]    out_allocated_block_o,
  output logic [gbba_pkg::ST_W-1:0]     out_status_o
);
  import gbba_pkg::*;

  localparam int RPG       = (MAX_BLOCKS_PER_GROUP + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W     = (RPG > 1) ? $clog2(RPG) : 1;
  localparam int MEM_ROWS  = MAX_GROUPS * RPG;
  localparam int AW        = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;
  localparam int GI_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int RST_COUNT = (MAX_BLOCKS_PER_GROUP < 1024) ? MAX_BLOCKS_PER_GROUP : 1024;
  localparam int PW0       = (ROW_W + ROW_SH > BPG_W) ? ROW_W + ROW_SH : BPG_W;
  localparam int PW        = PW0 + 1;

  // Configuration and effective values
  logic [BPG_W-1:0] cfg_bpg_q;
  logic [GRP_W-1:0] cfg_grp_q;
  logic [BPG_W-1:0] eff_bpg;
  logic [GI_W-1:0]  grp_last_idx;

  // Per-group free counts
  logic [CNT_W-1:0] count_q [MAX_GROUPS];

  // Walk state
  logic [CMD_W-1:0] cmd_q;
  logic [BLK_W-1:0] num_q;
  logic [BLK_W-1:0] rem_q;
  logic [BLK_W-1:0] blk_base_q;
  logic [GI_W-1:0]  grp_q;
  logic [AW-1:0]    row_base_q;
  logic [ROW_W-1:0] row_q;
  logic [AW-1:0]    addr_q;
  logic [AW-1:0]    clr_addr_q;

  // Bitmap memory
  logic [ROW_BITS-1:0] mem [MEM_ROWS];
  logic [ROW_BITS-1:0] rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ROW_BITS-1:0] mem_wdata;

  // Row search
  logic [ROW_W-1:0]    cur_row;
  logic [AW-1:0]       rd_addr;
  logic [PW-1:0]       span;
  logic [ROW_BITS-1:0] valid_mask;
  logic [ROW_BITS-1:0] masked;
  logic                row_found;
  logic [ROW_SH-1:0]   bit_idx;
  logic [ROW_SH-1:0]   free_bit;
  logic                bit_set;
  logic [BLK_W-1:0]    alloc_blk;

  // Results
  logic [ST_W-1:0]  res_st_q;
  logic [BLK_W-1:0] res_blk_q;
  logic             out_valid_q;
  logic [ST_W-1:0]  out_st_q;
  logic [BLK_W-1:0] out_blk_q;
  logic             out_free;

  // Capture configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bpg_q <= BPG_RST;
      cfg_grp_q <= GRP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BPG: cfg_bpg_q <= cfg_data_i;
        CFG_GRP: cfg_grp_q <= cfg_data_i[GRP_W-1:0];
        default: ;
      endcase
    end
  end

  // Round the group size down to whole bytes and clamp both registers
  always_comb begin
    int b;
    int n;
    b = int'({cfg_bpg_q[BPG_W-1:3], 3'b000});
    if (b < 8) b = 8;
    if (b > MAX_BLOCKS_PER_GROUP) b = MAX_BLOCKS_PER_GROUP;
    eff_bpg = BPG_W'(b);
    n = int'(cfg_grp_q);
    if (n < 1) n = 1;
    if (n > MAX_GROUPS) n = MAX_GROUPS;
    grp_last_idx = GI_W'(n - 1);
  end

  // Row addressing: free uses the in-group remainder, allocate walks rows
  assign cur_row = (cmd_q == CMD_FREE) ? rem_q[ROW_W+ROW_SH-1:ROW_SH] : row_q;
  assign rd_addr = row_base_q + AW'(cur_row);
  assign free_bit = rem_q[ROW_SH-1:0];

  // Mask off bits past the group end, then find the lowest clear bit
  always_comb begin
    span = PW'(eff_bpg) - PW'({row_q, {ROW_SH{1'b0}}});
    if (span >= PW'(ROW_BITS)) valid_mask = '1;
    else valid_mask = (ROW_BITS'(1) << span[ROW_SH-1:0]) - ROW_BITS'(1);
    masked = rdata_q | ~valid_mask;
    row_found = 1'b0;
    bit_idx = '0;
    for (int k = ROW_BITS - 1; k >= 0; k--) begin
      if (!masked[k]) begin
        row_found = 1'b1;
        bit_idx = ROW_SH'(k);
      end
    end
  end

  assign bit_set   = rdata_q[free_bit];
  assign alloc_blk = blk_base_q + BLK_W'({row_q, bit_idx}) + BLK_W'(1);

  // Select the memory write: clearing sweep or row update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = rdata_q;
    priority if (ctl_i.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else if (ctl_i.alloc_wr) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_q | (ROW_BITS'(1) << bit_idx);
    end else if (ctl_i.free_wr) begin
      mem_we    = bit_set;
      mem_wdata = rdata_q & ~(ROW_BITS'(1) << free_bit);
    end
  end

  // Bitmap memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (ctl_i.rd) begin
      rdata_q <= mem[rd_addr];
      addr_q  <= rd_addr;
    end
  end

  // Advance the clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (ctl_i.load && in_cmd_i == CMD_CLEAR) begin
      clr_addr_q <= '0;
    end else if (ctl_i.clr_step) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // Update free counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < MAX_GROUPS; g++) count_q[g] <= CNT_W'(RST_COUNT);
    end else if (ctl_i.load && in_cmd_i == CMD_CLEAR) begin
      for (int g = 0; g < MAX_GROUPS; g++) count_q[g] <= CNT_W'(eff_bpg);
    end else if (ctl_i.alloc_wr) begin
      count_q[grp_q] <= count_q[grp_q] - CNT_W'(1);
    end else if (ctl_i.free_wr && bit_set && count_q[grp_q] != COUNT_MAX) begin
      count_q[grp_q] <= count_q[grp_q] + CNT_W'(1);
    end
  end

  // Walk registers: capture the transaction, step groups and rows
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q      <= in_cmd_i;
      num_q      <= in_block_number_i;
      rem_q      <= in_block_number_i - BLK_W'(1);
      blk_base_q <= '0;
      grp_q      <= '0;
      row_base_q <= '0;
      row_q      <= '0;
    end else begin
      if (ctl_i.grp_next) begin
        rem_q      <= rem_q - BLK_W'(eff_bpg);
        blk_base_q <= blk_base_q + BLK_W'(eff_bpg);
        grp_q      <= grp_q + GI_W'(1);
        row_base_q <= row_base_q + AW'(RPG);
      end
      if (ctl_i.row_next) row_q <= row_q + ROW_W'(1);
    end
  end

  // Result of the transaction in flight
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      res_st_q  <= ST_OK;
      res_blk_q <= '0;
    end else if (ctl_i.alloc_wr) begin
      res_blk_q <= alloc_blk;
    end else if (ctl_i.set_full) begin
      res_st_q <= ST_FULL;
    end else if (ctl_i.set_bad) begin
      res_st_q <= ST_BAD;
    end
  end

  // Output register: hold until taken
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_st_q  <= res_st_q;
      out_blk_q <= res_blk_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_status_o          = out_st_q;
  assign out_allocated_block_o = out_blk_q;

  // Status toward the controller
  assign sts_o.grp_nz     = (count_q[grp_q] != '0);
  assign sts_o.grp_last   = (grp_q == grp_last_idx);
  assign sts_o.num_zero   = (num_q == '0);
  assign sts_o.rem_lt_bpg = (rem_q < BLK_W'(eff_bpg));
  assign sts_o.row_found  = row_found;
  assign sts_o.row_last   = (span <= PW'(ROW_BITS));
  assign sts_o.clr_last   = (clr_addr_q == AW'(MEM_ROWS - 1));
  assign sts_o.out_free   = out_free;

endmodule

// ===== src/grouped_bitmap_block_allocator_top.sv =====
// Top level of the grouped bitmap block allocator.
// Depends on gbba_pkg, gbba_ctrl and gbba_dp.
`timescale 1ns / 1ps

// Grouped bitmap block allocator. Commands arrive one transaction at a time
// on the in channel (allocate, free, clear, no operation) and each yields one
// result transaction. The used bits live in a memory of 64-bit rows,
// ceil(MAX_BLOCKS_PER_GROUP/64) rows per group. An allocate is accepted, walks
// the groups to find a nonzero free count, then reads bitmap rows in turn
// (registered memory read, then search) and hands the result over. A free
// walks groups by repeated subtraction of the group size, one group per
// cycle, then reads one row and rewrites it if the block's bit was set. A
// clear sweeps every memory row, one per cycle. After reset the same sweep
// runs with in_stall_o high; configuration writes are taken at any time. A
// new command is accepted while the previous result still waits to be taken.
module grouped_bitmap_block_allocator_top #(
  parameter int MAX_GROUPS           = 8,
  parameter int MAX_BLOCKS_PER_GROUP = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gbba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gbba_pkg::BPG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gbba_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [gbba_pkg::BLK_W-1:0]     in_block_number_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gbba_pkg::BLK_W-1:0]     out_allocated_block_o,
  output logic [gbba_pkg::ST_W-1:0]      out_status_o
);
  import gbba_pkg::*;

  ctrl_t ctl;
  sts_t  sts;

  // Sequencer
  gbba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_cmd_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Storage and arithmetic
  gbba_dp #(
    .MAX_GROUPS           (MAX_GROUPS),
    .MAX_BLOCKS_PER_GROUP (MAX_BLOCKS_PER_GROUP)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_cmd_i              (in_cmd_i),
    .in_block_number_i     (in_block_number_i),
    .ctl_i                 (ctl),
    .sts_o                 (sts),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_allocated_block_o (out_allocated_block_o),
    .out_status_o          (out_status_o)
  );

endmodule
